[hw/rtl/kccm_pkg.sv]
package kccm_pkg;

	// default configuration of the generic sizes
	localparam int KCCM_MER_BITS = 64;
	localparam int KCCM_PAIRS = 6;

	// matrix shape: fragment rows by contig columns
	localparam int KCCM_CATEGORIES = 6;
	localparam int KCCM_COLS = KCCM_CATEGORIES - 1;
	localparam int KCCM_CELLS = KCCM_CATEGORIES * KCCM_COLS;
	localparam int KCCM_MAX_PAIRS = 6;

	// pairs below this use the all-fragments mode
	localparam logic [2:0] KCCM_PAIRS_ALL = 3'd3;

	localparam int MODE_W = 14;
	localparam int COUNT_W = 32;
	localparam logic [MODE_W-1:0] MODE_RESET = 14'd16;

	// contig bin limits
	localparam logic [COUNT_W-1:0] CONTIG_LIM_LOW = 32'd10;
	localparam logic [COUNT_W-1:0] CONTIG_LIM_HIGH = 32'd100;

	// item function codes
	localparam logic FUNC_COMPARE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// configuration register indexes
	localparam logic CFG_MODE_ALL = 1'b0;
	localparam logic CFG_MODE_TRIM = 1'b1;

	// dump classes
	localparam logic [2:0] DUMP_NONE = 3'd0;
	localparam logic [2:0] DUMP_SINGLE_ZERO = 3'd1;
	localparam logic [2:0] DUMP_MULTI_ZERO = 3'd2;
	localparam logic [2:0] DUMP_OVER_LOW = 3'd3;
	localparam logic [2:0] DUMP_OVER_MULTI = 3'd4;

	// decision for one item, from classifier to the update stage
	typedef struct packed {
		logic hit;
		logic rd;
		logic [2:0] row;
		logic [2:0] col;
		logic [2:0] dclass;
		logic [4:0] slot;
	} step_t;

endpackage

[hw/rtl/kccm_ram.sv]
module kccm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 180
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/kccm_classify.sv]
module kccm_classify
	import kccm_pkg::*;
#(
	parameter int MER_BITS = KCCM_MER_BITS,
	parameter int PAIRS = KCCM_PAIRS
) (
	input logic func,
	input logic [2:0] pair,
	input logic [MER_BITS-1:0] frag_mer,
	input logic [COUNT_W-1:0] frag_count,
	input logic frag_valid,
	input logic [MER_BITS-1:0] contig_mer,
	input logic [COUNT_W-1:0] contig_count,
	input logic contig_valid,
	input logic [MER_BITS-1:0] min_mer,
	input logic [2:0] read_row,
	input logic [2:0] read_col,
	input logic [MODE_W-1:0] mode_all,
	input logic [MODE_W-1:0] mode_trim,
	output step_t step
);

	localparam logic [2:0] PAIRS_LIM = 3'(PAIRS);

	logic pair_ok;
	logic [MODE_W-1:0] mode;
	logic [COUNT_W-1:0] lim2, lim10, lim100;
	logic [2:0] fb, cb;
	logic fm_eq, cm_eq, fc_eq;
	logic hit;
	logic [2:0] row, col, dclass;
	logic [2:0] sel_row, sel_col;

	assign pair_ok = pair < PAIRS_LIM;
	assign mode = (pair < KCCM_PAIRS_ALL) ? mode_all : mode_trim;

	// mode-relative limits by shift and add
	assign lim2 = COUNT_W'({mode, 1'b0});
	assign lim10 = COUNT_W'({mode, 3'b000}) + COUNT_W'({mode, 1'b0});
	assign lim100 = COUNT_W'({mode, 6'd0}) + COUNT_W'({mode, 5'd0})
		+ COUNT_W'({mode, 2'b00});

	// fragment bin
	always_comb begin
		if (!frag_valid || frag_count == '0) begin
			fb = 3'd0;
		end else if (frag_count == COUNT_W'(1)) begin
			fb = 3'd1;
		end else if (frag_count <= lim2) begin
			fb = 3'd2;
		end else if (frag_count <= lim10) begin
			fb = 3'd3;
		end else if (frag_count <= lim100) begin
			fb = 3'd4;
		end else begin
			fb = 3'd5;
		end
	end

	// contig bin
	always_comb begin
		if (!contig_valid || contig_count == '0) begin
			cb = 3'd0;
		end else if (contig_count == COUNT_W'(1)) begin
			cb = 3'd1;
		end else if (contig_count <= CONTIG_LIM_LOW) begin
			cb = 3'd2;
		end else if (contig_count <= CONTIG_LIM_HIGH) begin
			cb = 3'd3;
		end else begin
			cb = 3'd4;
		end
	end

	assign fm_eq = frag_mer == min_mer;
	assign cm_eq = contig_mer == min_mer;
	assign fc_eq = frag_mer == contig_mer;

	// merge step decision
	always_comb begin
		hit = 1'b0;
		row = 3'd0;
		col = 3'd0;
		dclass = DUMP_NONE;
		if (fb == 3'd0 || cb == 3'd0) begin
			if ((fb == 3'd0 && cm_eq) || (cb == 3'd0 && fm_eq)) begin
				hit = 1'b1;
				row = fb;
				col = cb;
				if (fb == 3'd0) begin
					dclass = (cb == 3'd1) ? DUMP_SINGLE_ZERO : DUMP_MULTI_ZERO;
				end
			end
		end else if (!fc_eq) begin
			if (fm_eq) begin
				hit = 1'b1;
				row = fb;
			end else if (cm_eq) begin
				hit = 1'b1;
				col = cb;
				dclass = (cb == 3'd1) ? DUMP_SINGLE_ZERO : DUMP_MULTI_ZERO;
			end
		end else if (fm_eq) begin
			hit = 1'b1;
			row = fb;
			col = cb;
			if (fb < cb) begin
				dclass = (cb == 3'd2) ? DUMP_OVER_LOW : DUMP_OVER_MULTI;
			end
		end
	end

	// pick the cell for a compare or a read
	always_comb begin
		step = '0;
		if (pair_ok) begin
			if (func == FUNC_READ) begin
				step.rd = (read_row < 3'(KCCM_CATEGORIES)) && (read_col < 3'(KCCM_COLS));
				sel_row = read_row;
				sel_col = read_col;
			end else begin
				step.hit = hit;
				step.row = hit ? row : 3'd0;
				step.col = hit ? col : 3'd0;
				step.dclass = hit ? dclass : DUMP_NONE;
				sel_row = row;
				sel_col = col;
			end
			if (step.rd || step.hit) begin
				step.slot = 5'({2'b00, sel_row} * 5'(KCCM_COLS)) + 5'({2'b00, sel_col});
			end
		end else begin
			sel_row = 3'd0;
			sel_col = 3'd0;
		end
	end

endmodule

[hw/rtl/kmer_count_category_matrix.sv]
// results pass the stage 1 and output registers; throughput: one item per
//   cycle unless the output stalls; the counter read-modify-write is one memory
//   read plus one write, with the previous write forwarded to the next item
// reset clears all counters through per-entry valid bits at once, sets both
//   modes to 16 and empties the pipeline; items are taken right after reset
module kmer_count_category_matrix
	import kccm_pkg::*;
#(
	parameter int MER_BITS = KCCM_MER_BITS,
	parameter int PAIRS = KCCM_PAIRS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [2:0] pair,
	input logic [MER_BITS-1:0] frag_mer,
	input logic [COUNT_W-1:0] frag_count,
	input logic frag_valid,
	input logic [MER_BITS-1:0] contig_mer,
	input logic [COUNT_W-1:0] contig_count,
	input logic contig_valid,
	input logic [MER_BITS-1:0] min_mer,
	input logic [2:0] read_row,
	input logic [2:0] read_col,
	output logic out_valid,
	input logic out_stall,
	output logic counted,
	output logic [2:0] cell_row,
	output logic [2:0] cell_col,
	output logic [2:0] dump_class,
	output logic [COUNT_W-1:0] read_value,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [MODE_W-1:0] cfg_data
);

	localparam int DEPTH = PAIRS * KCCM_CELLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FULL_W = $clog2(KCCM_MAX_PAIRS * KCCM_CELLS);

	logic [MODE_W-1:0] mode_all_q, mode_trim_q;
	step_t step;
	logic [ADDR_W-1:0] addr;
	logic in_accept, adv;

	logic valid_s1;
	step_t st_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic wr_en_s2;
	logic [ADDR_W-1:0] wr_addr_s2;
	logic [COUNT_W-1:0] wr_data_s2;

	logic [DEPTH-1:0] vld_q;
	logic [COUNT_W-1:0] ram_rdata, cur, nxt;
	logic we;

	logic out_valid_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_all_q <= MODE_RESET;
			mode_trim_q <= MODE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE_ALL: mode_all_q <= cfg_data;
				CFG_MODE_TRIM: mode_trim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bin and decide
	kccm_classify #(
		.MER_BITS(MER_BITS),
		.PAIRS(PAIRS)
	) u_classify (
		.func(func),
		.pair(pair),
		.frag_mer(frag_mer),
		.frag_count(frag_count),
		.frag_valid(frag_valid),
		.contig_mer(contig_mer),
		.contig_count(contig_count),
		.contig_valid(contig_valid),
		.min_mer(min_mer),
		.read_row(read_row),
		.read_col(read_col),
		.mode_all(mode_all_q),
		.mode_trim(mode_trim_q),
		.step(step)
	);

	// counter address: pair times cells plus cell
	assign addr = (step.hit || step.rd)
		? ADDR_W'(FULL_W'(pair) * FULL_W'(KCCM_CELLS) + FULL_W'(step.slot))
		: '0;

	// handshake
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	// counter memory
	assign we = adv && valid_s1 && st_s1.hit;

	kccm_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(addr_s1),
		.wdata(nxt),
		.re(in_accept),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			st_s1 <= step;
			addr_s1 <= addr;
		end
	end

	// current count: forward the last write, unwritten entries read as zero
	always_comb begin
		if (wr_en_s2 && wr_addr_s2 == addr_s1) begin
			cur = wr_data_s2;
		end else if (vld_q[addr_s1]) begin
			cur = ram_rdata;
		end else begin
			cur = '0;
		end
	end

	// saturating increment
	assign nxt = (&cur) ? cur : cur + COUNT_W'(1);

	// last write and per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s2 <= 1'b0;
			vld_q <= '0;
		end else if (we) begin
			wr_en_s2 <= 1'b1;
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wr_addr_s2 <= addr_s1;
			wr_data_s2 <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			counted <= st_s1.hit;
			cell_row <= st_s1.row;
			cell_col <= st_s1.col;
			dump_class <= st_s1.dclass;
			read_value <= st_s1.rd ? cur : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[verif/kccm_tally_pkg.sv]
package kccm_tally_pkg;
	import kccm_pkg::*;

	// one item as offered on the input channel, in port order
	typedef struct packed {
		logic func;
		logic [2:0] pair;
		logic [KCCM_MER_BITS-1:0] frag_mer;
		logic [COUNT_W-1:0] frag_count;
		logic frag_valid;
		logic [KCCM_MER_BITS-1:0] contig_mer;
		logic [COUNT_W-1:0] contig_count;
		logic contig_valid;
		logic [KCCM_MER_BITS-1:0] min_mer;
		logic [2:0] read_row;
		logic [2:0] read_col;
	} step_item_t;

	// one result as seen on the output channel, in port order
	typedef struct packed {
		logic counted;
		logic [2:0] row;
		logic [2:0] col;
		logic [2:0] dclass;
		logic [COUNT_W-1:0] value;
	} step_result_t;

	class category_tally;
		logic [MODE_W-1:0] mode_all;
		logic [MODE_W-1:0] mode_trim;
		logic [COUNT_W-1:0] counters [KCCM_MAX_PAIRS*KCCM_CELLS];
		step_result_t awaited [$];
		int failures;

		function new();
			mode_all = MODE_RESET;
			mode_trim = MODE_RESET;
			foreach (counters[i])
				counters[i] = '0;
			failures = 0;
		endfunction

		function void set_mode(logic index, logic [MODE_W-1:0] value);
			if (index == CFG_MODE_ALL)
				mode_all = value;
			else
				mode_trim = value;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int cell_index(logic [2:0] pair, logic [2:0] row, logic [2:0] col);
			return int'(pair) * KCCM_CELLS + int'(row) * KCCM_COLS + int'(col);
		endfunction

		// fragment row, limits relative to the mode (wide enough for 100 * mode)
		function logic [2:0] frag_row(logic [COUNT_W-1:0] cnt, logic [MODE_W-1:0] mode);
			logic [47:0] c;
			logic [47:0] m;
			c = cnt;
			m = mode;
			if (c == 0)
				return 3'd0;
			if (c == 1)
				return 3'd1;
			if (c <= 2 * m)
				return 3'd2;
			if (c <= 10 * m)
				return 3'd3;
			if (c <= 100 * m)
				return 3'd4;
			return 3'd5;
		endfunction

		function logic [2:0] contig_col(logic [COUNT_W-1:0] cnt);
			if (cnt == 0)
				return 3'd0;
			if (cnt == 1)
				return 3'd1;
			if (cnt <= CONTIG_LIM_LOW)
				return 3'd2;
			if (cnt <= CONTIG_LIM_HIGH)
				return 3'd3;
			return 3'd4;
		endfunction

		// works out the result of one item and applies its counter update
		function step_result_t tally_step(step_item_t it);
			step_result_t r;
			logic [2:0] fb;
			logic [2:0] cb;
			logic [MODE_W-1:0] mode;
			int idx;
			r = '0;
			if (it.pair >= KCCM_PAIRS)
				return r;
			if (it.func == FUNC_READ) begin
				if (it.read_row < KCCM_CATEGORIES && it.read_col < KCCM_COLS)
					r.value = counters[cell_index(it.pair, it.read_row, it.read_col)];
				return r;
			end
			mode = (it.pair < KCCM_PAIRS_ALL) ? mode_all : mode_trim;
			fb = it.frag_valid ? frag_row(it.frag_count, mode) : 3'd0;
			cb = it.contig_valid ? contig_col(it.contig_count) : 3'd0;
			if (fb == 0 || cb == 0) begin
				// one side empty: only the side on the minimum can count
				if ((fb == 0 && it.contig_mer == it.min_mer) ||
						(cb == 0 && it.frag_mer == it.min_mer)) begin
					r.counted = 1'b1;
					r.row = fb;
					r.col = cb;
					if (fb == 0)
						r.dclass = (cb == 1) ? DUMP_SINGLE_ZERO : DUMP_MULTI_ZERO;
				end
			end else if (it.frag_mer != it.contig_mer) begin
				// different k-mers: the one on the minimum counts alone
				if (it.frag_mer == it.min_mer) begin
					r.counted = 1'b1;
					r.row = fb;
				end else if (it.contig_mer == it.min_mer) begin
					r.counted = 1'b1;
					r.col = cb;
					r.dclass = (cb == 1) ? DUMP_SINGLE_ZERO : DUMP_MULTI_ZERO;
				end
			end else if (it.frag_mer == it.min_mer) begin
				// shared k-mer on the minimum
				r.counted = 1'b1;
				r.row = fb;
				r.col = cb;
				if (fb < cb)
					r.dclass = (cb == 2) ? DUMP_OVER_LOW : DUMP_OVER_MULTI;
			end
			if (r.counted) begin
				idx = cell_index(it.pair, r.row, r.col);
				if (counters[idx] != '1)
					counters[idx] = counters[idx] + 1;
			end
			return r;
		endfunction

		function void note_item(step_item_t it);
			awaited.push_back(tally_step(it));
		endfunction

		function void compare_field(string name, logic [COUNT_W-1:0] want,
				logic [COUNT_W-1:0] got);
			if (want !== got) begin
				failures++;
				if (failures <= 10)
					$display("mismatch on %s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_result(step_result_t got);
			step_result_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result with nothing awaited: counted %0b value %0h",
						got.counted, got.value);
				return;
			end
			want = awaited.pop_front();
			compare_field("counted", want.counted, got.counted);
			compare_field("cell_row", want.row, got.row);
			compare_field("cell_col", want.col, got.col);
			compare_field("dump_class", want.dclass, got.dclass);
			compare_field("read_value", want.value, got.value);
		endfunction
	endclass

endpackage

[verif/kmer_count_category_matrix_test.sv]
module kmer_count_category_matrix_test;
	import kccm_pkg::*;
	import kccm_tally_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [2:0] pair;
	logic [KCCM_MER_BITS-1:0] frag_mer;
	logic [COUNT_W-1:0] frag_count;
	logic frag_valid;
	logic [KCCM_MER_BITS-1:0] contig_mer;
	logic [COUNT_W-1:0] contig_count;
	logic contig_valid;
	logic [KCCM_MER_BITS-1:0] min_mer;
	logic [2:0] read_row;
	logic [2:0] read_col;
	logic out_valid;
	logic out_stall;
	logic counted;
	logic [2:0] cell_row;
	logic [2:0] cell_col;
	logic [2:0] dump_class;
	logic [COUNT_W-1:0] read_value;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [MODE_W-1:0] cfg_data;

	category_tally tally;
	bit tx_quiet;
	bit rx_quiet;
	bit hold_req;
	int burst_left;
	int idle_cycles;

	kmer_count_category_matrix dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly no wait, now and then a wait of random length
	function automatic int draw_wait();
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
	endfunction

	function automatic logic [KCCM_MER_BITS-1:0] rand_mer();
		return {$urandom, $urandom};
	endfunction

	// a k-mer that differs from m, often by a single bit
	function automatic logic [KCCM_MER_BITS-1:0] other_mer(logic [KCCM_MER_BITS-1:0] m);
		logic [KCCM_MER_BITS-1:0] o;
		if ($urandom_range(0, 1) == 0)
			o = m ^ (64'd1 << $urandom_range(0, KCCM_MER_BITS - 1));
		else
			o = rand_mer();
		if (o == m)
			o = ~m;
		return o;
	endfunction

	// fragment counts around the mode-relative bin limits
	function automatic logic [COUNT_W-1:0] frag_count_near(logic [MODE_W-1:0] mode);
		logic [COUNT_W-1:0] m;
		m = mode;
		case ($urandom_range(0, 11))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 2 * m;
			4: return 2 * m + 1;
			5: return 10 * m;
			6: return 10 * m + 1;
			7: return 100 * m;
			8: return 100 * m + 1;
			9: return $urandom_range(2, 100 * m + 2);
			10: return $urandom;
			default: return '1;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] contig_count_near();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return CONTIG_LIM_LOW;
			4: return CONTIG_LIM_LOW + 1;
			5: return CONTIG_LIM_HIGH;
			6: return CONTIG_LIM_HIGH + 1;
			7: return $urandom_range(2, 150);
			8: return $urandom;
			default: return '1;
		endcase
	endfunction

	function automatic step_item_t mk(logic f, logic [2:0] p,
			logic [KCCM_MER_BITS-1:0] fm, logic [COUNT_W-1:0] fc, logic fv,
			logic [KCCM_MER_BITS-1:0] cm, logic [COUNT_W-1:0] cc, logic cv,
			logic [KCCM_MER_BITS-1:0] mm, logic [2:0] rr, logic [2:0] rc);
		return {f, p, fm, fc, fv, cm, cc, cv, mm, rr, rc};
	endfunction

	// mostly merge steps with k-mers on or near the minimum, some reads and noise
	function automatic step_item_t random_item();
		step_item_t it;
		logic [MODE_W-1:0] mode;
		int kind;
		it.func = FUNC_COMPARE;
		it.pair = $urandom_range(0, KCCM_PAIRS - 1);
		it.frag_mer = rand_mer();
		it.contig_mer = rand_mer();
		it.min_mer = rand_mer();
		it.frag_count = $urandom;
		it.contig_count = $urandom;
		it.frag_valid = ($urandom_range(0, 7) != 0);
		it.contig_valid = ($urandom_range(0, 7) != 0);
		it.read_row = $urandom_range(0, 7);
		it.read_col = $urandom_range(0, 7);
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			it.func = FUNC_READ;
			if ($urandom_range(0, 7) != 0) begin
				it.read_row = $urandom_range(0, KCCM_CATEGORIES - 1);
				it.read_col = $urandom_range(0, KCCM_COLS - 1);
			end
			if ($urandom_range(0, 15) == 0)
				it.pair = $urandom_range(KCCM_PAIRS, 7);
			return it;
		end
		if (kind < 25) begin
			it.pair = $urandom_range(KCCM_PAIRS, 7);
			return it;
		end
		if (kind < 35)
			return it;
		mode = (it.pair < KCCM_PAIRS_ALL) ? tally.mode_all : tally.mode_trim;
		it.frag_count = frag_count_near(mode);
		it.contig_count = contig_count_near();
		case ($urandom_range(0, 3))
			0: begin
				it.frag_mer = it.min_mer;
				it.contig_mer = it.min_mer;
			end
			1: begin
				it.frag_mer = it.min_mer;
				it.contig_mer = other_mer(it.min_mer);
			end
			2: begin
				it.contig_mer = it.min_mer;
				it.frag_mer = other_mer(it.min_mer);
			end
			default: begin
				it.frag_mer = other_mer(it.min_mer);
				it.contig_mer = it.frag_mer;
			end
		endcase
		return it;
	endfunction

	// offer one item and hold it until taken
	task automatic send_item(step_item_t it);
		int gap;
		gap = (tx_quiet || burst_left > 0) ? 0 : draw_wait();
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{func, pair, frag_mer, frag_count, frag_valid, contig_mer, contig_count,
			contig_valid, min_mer, read_row, read_col} <= it;
		do @(posedge clk); while (in_stall);
		tally.note_item(it);
	endtask

	// stop offering and wait for every awaited result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tally.pending() != 0)
			@(posedge clk);
	endtask

	// both mode registers, written back to back while the block is idle
	task automatic write_modes(logic [MODE_W-1:0] all_mode, logic [MODE_W-1:0] trim_mode);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MODE_ALL;
		cfg_data <= all_mode;
		do @(posedge clk); while (!cfg_ready);
		tally.set_mode(CFG_MODE_ALL, all_mode);
		cfg_index <= CFG_MODE_TRIM;
		cfg_data <= trim_mode;
		do @(posedge clk); while (!cfg_ready);
		tally.set_mode(CFG_MODE_TRIM, trim_mode);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			send_item(random_item());
		end
	endtask

	// every compare rule, several bin edges at the reset mode, and the out-of-range cases
	task automatic directed_items();
		logic [KCCM_MER_BITS-1:0] a;
		logic [KCCM_MER_BITS-1:0] b;
		logic [KCCM_MER_BITS-1:0] z;
		logic [KCCM_MER_BITS-1:0] ones;
		a = 64'h0123_4567_89ab_cdef;
		b = a ^ 64'd1;
		z = '0;
		ones = '1;
		send_item(mk(FUNC_COMPARE, 3'd0, a, 0, 1'b1, a, 1, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd1, b, 7, 1'b0, a, 5, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd2, a, 0, 1'b1, b, 0, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd3, b, 0, 1'b1, b, 0, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd4, a, 1000, 1'b1, b, 50, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd5, b, 2, 1'b1, a, 1, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd0, b, 33, 1'b1, a, 500, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd1, b, 33, 1'b1, ones, 500, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd2, b, 33, 1'b1, b, 50, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd3, a, 32, 1'b1, a, 5, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd4, a, 1, 1'b1, a, 5, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd5, a, 1, 1'b1, a, 50, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd0, ones, '1, 1'b1, ones, '1, 1'b1, ones, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd1, z, 33, 1'b1, ones, 7, 1'b0, z, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd2, z, 161, 1'b1, z, 101, 1'b1, z, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd6, a, 0, 1'b1, a, 1, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd7, a, 0, 1'b1, a, 1, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_COMPARE, 3'd3, a, 2, 1'b1, a, 11, 1'b1, a, 3'd0, 3'd0));
		send_item(mk(FUNC_READ, 3'd0, z, 0, 1'b0, z, 0, 1'b0, z, 3'd0, 3'd1));
		send_item(mk(FUNC_READ, 3'd0, z, 0, 1'b0, z, 0, 1'b0, z, 3'd6, 3'd0));
		send_item(mk(FUNC_READ, 3'd0, z, 0, 1'b0, z, 0, 1'b0, z, 3'd0, 3'd5));
		send_item(mk(FUNC_READ, 3'd7, z, 0, 1'b0, z, 0, 1'b0, z, 3'd0, 3'd1));
		send_item(mk(FUNC_READ, 3'd5, z, 0, 1'b0, z, 0, 1'b0, z, 3'd1, 3'd3));
		send_item(mk(FUNC_READ, 3'd2, z, 0, 1'b0, z, 0, 1'b0, z, 3'd0, 3'd0));
		send_item(mk(FUNC_READ, 3'd3, z, 0, 1'b0, z, 0, 1'b0, z, 3'd2, 3'd2));
	endtask

	// result side: random stalls, one long hold on request
	initial begin : result_sink
		int hold;
		step_result_t got;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		hold = rx_quiet ? 0 : draw_wait();
		out_stall <= (hold > 0);
		forever begin
			if (hold > 0) begin
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got = {counted, cell_row, cell_col, dump_class, read_value};
			tally.check_result(got);
			if (hold_req) begin
				hold = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				hold = rx_quiet ? 0 : draw_wait();
			end
			out_stall <= (hold > 0);
		end
	end

	// reset, then phases of items at several mode settings
	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MODE_ALL;
		cfg_data <= '0;
		{func, pair, frag_mer, frag_count, frag_valid, contig_mer, contig_count,
			contig_valid, min_mer, read_row, read_col} <= '0;
		tally = new();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		run_random(180);

		write_modes(14'd0, 14'h3FFF);
		run_random(250);

		// receiver holds off while the sender keeps offering back to back
		write_modes(14'h3FFF, 14'd0);
		run_random(120);
		hold_req = 1'b1;
		burst_left = 60;
		run_random(130);

		// sender pauses until the pipeline is empty
		write_modes(14'd1, 14'd7);
		run_random(100);
		drain();
		run_random(150);

		write_modes($urandom_range(0, 16383), $urandom_range(0, 16383));
		run_random(200);
		write_modes($urandom_range(0, 16383), $urandom_range(0, 16383));
		run_random(150);

		drain();
		repeat (8) @(posedge clk);
		if (tally.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/kccm_pkg.sv
hw/rtl/kccm_ram.sv
hw/rtl/kccm_classify.sv
hw/rtl/kmer_count_category_matrix.sv
verif/kccm_tally_pkg.sv
verif/kmer_count_category_matrix_test.sv
